FILE: rtl/smhu_pkg.sv
// ----------------------------------------------------------------------------
// SPI master message handshake package
// Shared event, phase and action codes plus the job record that passes from
// the event front end to the result back end.
// ----------------------------------------------------------------------------
package smhu_pkg;

  // Number of bytes in a message header: four length bytes, two port bytes.
  localparam int unsigned HEADER_BYTES = 6;

  // Timeout register value after reset.
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Input events.
  typedef enum logic [2:0] {
    CMD_IRQ_FALL = 3'd0,
    CMD_IRQ_RISE = 3'd1,
    CMD_SEND_REQ = 3'd2,
    CMD_XFER_DONE = 3'd3,
    CMD_HDR_BYTE = 3'd4,
    CMD_TICK = 3'd5
  } cmd_e;

  // Controller phases.
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_SEND_CMD = 4'd1,
    PH_SEND_WAIT = 4'd2,
    PH_SEND_MSG = 4'd3,
    PH_SEND_DONE = 4'd4,
    PH_RX_WAIT_CMD = 4'd5,
    PH_RX_CMD = 4'd6,
    PH_RX_WAIT_MSG = 4'd7,
    PH_RX_MSG = 4'd8,
    PH_IDLE_WAIT = 4'd9
  } phase_e;

  // Actions reported with each result.
  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_TX_HDR = 3'd1,
    ACT_TX_MSG = 3'd2,
    ACT_RX_HDR = 3'd3,
    ACT_RX_MSG = 3'd4
  } action_e;

  // One classified event. A header job carries the send port and length,
  // which the back end slices into six header bytes.
  typedef struct packed {
    action_e     action;
    logic        send_complete;
    logic        recv_complete;
    logic [15:0] port;
    logic [31:0] length;
    phase_e      state;
  } job_t;

  // Chip select is driven low while a transfer phase is active.
  function automatic logic cs_level(phase_e ph);
    logic cs;
    cs = 1'b1;
    if (ph == PH_SEND_CMD || ph == PH_SEND_MSG || ph == PH_RX_CMD || ph == PH_RX_MSG) begin
      cs = 1'b0;
    end
    return cs;
  endfunction

endpackage

FILE: rtl/smhu_front.sv
// ----------------------------------------------------------------------------
// SPI master message handshake front end
// Accepts one event per cycle while the job queue is not full, advances the
// handshake controller and turns each event into a job for the job queue.
// ----------------------------------------------------------------------------
module smhu_front import smhu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] port_i,
  input  logic [31:0] length_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output job_t        job_o
);

  phase_e      phase_q, phase_d;
  logic        irq_q, irq_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] tmo_q, tmo_d;
  logic [31:0] send_len_q, send_len_d;
  logic [15:0] ticks_q;
  logic [7:0]  hdr_q [HEADER_BYTES];
  logic        hdr_load_tx;
  logic        hdr_load_rx;
  logic        in_fire;
  cmd_e        cmd;
  logic [31:0] parsed_len;
  logic [15:0] parsed_port;
  logic [47:0] hdr_tx_word;

  assign in_ready_o = ~queue_full_i;
  assign in_fire    = in_valid_i & ~queue_full_i;
  assign push_o     = in_fire;
  assign cmd        = cmd_e'(cmd_i);

  assign parsed_len  = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
  assign parsed_port = {hdr_q[5], hdr_q[4]};
  assign hdr_tx_word = {port_i, length_i};

  // Next-state logic of the handshake controller.
  always_comb begin
    phase_d     = phase_q;
    irq_d       = irq_q;
    idx_d       = idx_q;
    tmo_d       = tmo_q;
    send_len_d  = send_len_q;
    hdr_load_tx = 1'b0;
    hdr_load_rx = 1'b0;
    if (in_fire) begin
      unique case (cmd)
        CMD_IRQ_FALL: begin
          irq_d = 1'b0;
          if (phase_q == PH_SEND_WAIT) begin
            phase_d = PH_SEND_MSG;
          end else if (phase_q == PH_IDLE) begin
            phase_d = PH_RX_WAIT_CMD;
            tmo_d   = ticks_q;
          end else if (phase_q == PH_RX_WAIT_MSG) begin
            phase_d = PH_RX_MSG;
          end
        end
        CMD_IRQ_RISE: begin
          irq_d = 1'b1;
          if (phase_q == PH_SEND_DONE) begin
            phase_d = PH_IDLE;
          end else if (phase_q == PH_RX_WAIT_CMD) begin
            phase_d = PH_RX_CMD;
            tmo_d   = '0;
            idx_d   = '0;
          end else begin
            // An unexpected rise always drops back to idle.
            phase_d = PH_IDLE;
            tmo_d   = '0;
          end
        end
        CMD_SEND_REQ: begin
          if (phase_q == PH_IDLE && irq_q) begin
            phase_d     = PH_SEND_CMD;
            send_len_d  = length_i;
            hdr_load_tx = 1'b1;
          end
        end
        CMD_XFER_DONE: begin
          unique case (phase_q)
            PH_SEND_CMD: phase_d = PH_SEND_WAIT;
            PH_SEND_MSG: phase_d = PH_SEND_DONE;
            PH_RX_CMD:   phase_d = PH_RX_WAIT_MSG;
            PH_RX_MSG:   phase_d = PH_IDLE_WAIT;
            default:     phase_d = phase_q;
          endcase
        end
        CMD_HDR_BYTE: begin
          if (phase_q == PH_RX_CMD && idx_q < 3'(HEADER_BYTES)) begin
            hdr_load_rx = 1'b1;
            idx_d       = idx_q + 3'd1;
          end
        end
        CMD_TICK: begin
          if (phase_q == PH_RX_WAIT_CMD) begin
            if (tmo_q <= 16'd1) begin
              tmo_d   = '0;
              phase_d = PH_IDLE;
            end else begin
              tmo_d = tmo_q - 16'd1;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Job contents for the event being accepted.
  always_comb begin
    job_o.action        = ACT_NONE;
    job_o.send_complete = 1'b0;
    job_o.recv_complete = 1'b0;
    job_o.port          = '0;
    job_o.length        = '0;
    job_o.state         = phase_d;
    unique case (cmd)
      CMD_IRQ_FALL: begin
        if (phase_q == PH_SEND_WAIT) begin
          job_o.action = ACT_TX_MSG;
          job_o.length = send_len_q;
        end else if (phase_q == PH_RX_WAIT_MSG) begin
          job_o.action = ACT_RX_MSG;
          job_o.port   = parsed_port;
          job_o.length = parsed_len;
        end
      end
      CMD_IRQ_RISE: begin
        if (phase_q == PH_SEND_DONE) begin
          job_o.send_complete = 1'b1;
        end else if (phase_q == PH_RX_WAIT_CMD) begin
          job_o.action = ACT_RX_HDR;
        end
      end
      CMD_SEND_REQ: begin
        if (phase_q == PH_IDLE && irq_q) begin
          job_o.action = ACT_TX_HDR;
          job_o.port   = port_i;
          job_o.length = length_i;
        end
      end
      CMD_XFER_DONE: begin
        if (phase_q == PH_RX_MSG) begin
          job_o.recv_complete = 1'b1;
          job_o.port          = parsed_port;
          job_o.length        = parsed_len;
        end
      end
      default: begin
        job_o.action = ACT_NONE;
      end
    endcase
  end

  // Controller state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      irq_q      <= 1'b1;
      idx_q      <= '0;
      tmo_q      <= '0;
      send_len_q <= '0;
      ticks_q    <= TIMEOUT_RESET;
    end else begin
      phase_q    <= phase_d;
      irq_q      <= irq_d;
      idx_q      <= idx_d;
      tmo_q      <= tmo_d;
      send_len_q <= send_len_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
    end
  end

  // Header byte store: loaded whole by a send, one byte at a time on receive.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (hdr_load_tx) begin
        hdr_q[i] <= hdr_tx_word[i*8 +: 8];
      end else if (hdr_load_rx && idx_q == 3'(i)) begin
        hdr_q[i] <= rx_byte_i;
      end
    end
  end

endmodule

FILE: rtl/smhu_queue.sv
// ----------------------------------------------------------------------------
// SPI master message handshake job queue
// Small first-in first-out buffer of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module smhu_queue import smhu_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: rtl/smhu_back.sv
// ----------------------------------------------------------------------------
// SPI master message handshake back end
// Drains jobs from the queue into the registered result stream, expanding a
// header job into six header byte transactions.
// ----------------------------------------------------------------------------
module smhu_back import smhu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [63:0] m_data_o,
  output logic [2:0]  m_user_o,
  output logic        m_last_o
);

  logic        valid_q, valid_d;
  logic [2:0]  byte_q, byte_d;
  logic [63:0] data_q;
  logic [2:0]  user_q;
  logic        last_q;
  logic        load;
  logic        is_hdr;
  logic        hdr_end;
  logic [47:0] hdr_word;
  logic [7:0]  tx_byte;
  logic [63:0] data_d;
  logic        last_d;

  assign load     = ~empty_i & (~valid_q | m_ready_i);
  assign is_hdr   = (head_i.action == ACT_TX_HDR);
  assign hdr_end  = (byte_q == 3'(HEADER_BYTES - 1));
  assign pop_o    = load & (~is_hdr | hdr_end);
  assign hdr_word = {head_i.port, head_i.length};
  assign tx_byte  = 8'(hdr_word >> {byte_q, 3'b000});

  // Result word: accepted, chip select, tx byte, completions, port, length,
  // state from the lowest bit up.
  always_comb begin
    if (is_hdr) begin
      data_d = {head_i.state, 32'd0, 16'd0, 1'b0, 1'b0, tx_byte,
                cs_level(head_i.state), 1'b1};
      last_d = hdr_end;
    end else begin
      data_d = {head_i.state, head_i.length, head_i.port, head_i.recv_complete,
                head_i.send_complete, 8'd0, cs_level(head_i.state), 1'b0};
      last_d = 1'b1;
    end
  end

  // Valid flag and header byte counter.
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load) begin
      valid_d = 1'b1;
      if (is_hdr) begin
        byte_d = hdr_end ? '0 : byte_q + 3'd1;
      end
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      byte_q  <= '0;
    end else begin
      valid_q <= valid_d;
      byte_q  <= byte_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      user_q <= head_i.action;
      last_q <= last_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = user_q;
  assign m_last_o  = last_q;

endmodule

FILE: rtl/spi_master_message_handshake_unit.sv
// ----------------------------------------------------------------------------
// SPI master message handshake unit
// Handshake controller for message transfer with an IRQ-signalling SPI slave.
// ----------------------------------------------------------------------------
// Usage: each slave-side transaction carries one event (IRQ fall, IRQ rise,
// send request, transfer done, received header byte, timer tick) with the
// event code on s_axis_tuser_i. Every event yields one result transaction on
// the master side; an accepted send request yields six, the little-endian
// header bytes, the last one flagged by m_axis_tlast_o. The timeout register
// must be loaded through cfg_we_i / cfg_wdata_i only while the unit is idle;
// the unit does not enforce it. Each accepted event passes through the job
// queue and then the output register. The front end takes one event per
// cycle while the queue is not full; the back end delivers one result per
// cycle while the receiver is ready, so a send request occupies the output
// for six results. A job queue of QUEUE_DEPTH entries lets the front end keep
// accepting meanwhile; when the queue is full s_axis_tready_o drops. A stalled
// receiver holds the output and, once the queue fills, stalls the input side.
// Reset puts the controller in idle with IRQ assumed high, empties the queue
// and restores the timeout to 1000 ticks.
// ----------------------------------------------------------------------------
module spi_master_message_handshake_unit import smhu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // port [15:0], length [47:16], rx_byte [55:48]
  input  logic [55:0] s_axis_tdata_i,
  // cmd [2:0]
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // accepted [0], chip_select [1], tx_byte [9:2], send_complete [10],
  // recv_complete [11], out_port [27:12], out_length [59:28], fsm_state [63:60]
  output logic [63:0] m_axis_tdata_o,
  // action [2:0]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head_job;

  // Event front end.
  smhu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .cmd_i        (s_axis_tuser_i),
    .port_i       (s_axis_tdata_i[15:0]),
    .length_i     (s_axis_tdata_i[47:16]),
    .rx_byte_i    (s_axis_tdata_i[55:48]),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Job queue.
  smhu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  // Result back end.
  smhu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .head_i    (head_job),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

  // Only header transactions may be non-final within an event's run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ACT_TX_HDR |-> m_axis_tlast_o)
    else $error("non-header result without tlast");

  // The accepted flag marks exactly the header transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[0] == (m_axis_tuser_o == ACT_TX_HDR)))
    else $error("accepted flag disagrees with action");

  // Header bytes go out with chip select asserted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ACT_TX_HDR |-> !m_axis_tdata_o[1])
    else $error("header byte sent without chip select");

  // No job may be taken while the queue is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty job queue");

endmodule

FILE: tb/spi_master_message_handshake_unit_test.sv
// ----------------------------------------------------------------------------
// SPI master message handshake unit testbench
// Drives event transactions into the unit with random gaps, and consumes its
// result transactions with random stalls. A behavioural model of the
// handshake controller predicts every result as each event is accepted.
// Results are checked field by field in order. The timeout register is
// reprogrammed between test phases while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_master_message_handshake_unit_test;
  import smhu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_EVENTS = 14;
  // Event codes that the controller does not define.
  localparam logic [2:0] CMD_RESERVED_LO = 3'd6;
  localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] port;
    logic [31:0] length;
    logic [7:0]  rx_byte;
  } event_t;

  typedef struct {
    logic        accepted;
    logic        chip_select;
    action_e     action;
    logic [7:0]  tx_byte;
    logic        last;
    logic        send_complete;
    logic        recv_complete;
    logic [15:0] port;
    logic [31:0] length;
    phase_e      state;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        drv_valid = 1'b0;
  logic [55:0] drv_data = '0;
  logic [2:0]  drv_cmd = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        sink_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Stimulus waiting for the driver and results waiting for the unit.
  event_t  pending_events[$];
  result_t expected_results[$];

  int unsigned fault_count = 0;
  int unsigned result_count = 0;
  int unsigned queued_events = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  logic        calm = 1'b0;

  // Shadow copy of the controller state.
  phase_e      ctl_phase = PH_IDLE;
  logic        irq_level = 1'b1;
  logic [7:0]  hdr_bytes[HEADER_BYTES];
  int unsigned hdr_index = 0;
  logic [15:0] tmo_count = '0;
  logic [15:0] tmo_ticks = TIMEOUT_RESET;
  logic [31:0] send_length = '0;

  spi_master_message_handshake_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(drv_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (drv_data),
    .s_axis_tuser_i (drv_cmd),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(sink_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none at all in a calm phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Builds one result; chip select and state follow the phase after the event.
  function automatic result_t make_result(logic acc, action_e act, logic [7:0] txb,
                                          logic lst, logic sc, logic rc,
                                          logic [15:0] prt, logic [31:0] len);
    result_t r;
    r.accepted = acc;
    r.chip_select = !(ctl_phase inside {PH_SEND_CMD, PH_SEND_MSG, PH_RX_CMD, PH_RX_MSG});
    r.action = act;
    r.tx_byte = txb;
    r.last = lst;
    r.send_complete = sc;
    r.recv_complete = rc;
    r.port = prt;
    r.length = len;
    r.state = ctl_phase;
    return r;
  endfunction

  // Advances the shadow controller by one event and queues its results.
  task automatic predict_event(input event_t ev);
    action_e     act;
    logic        sc;
    logic        rc;
    logic [15:0] prt;
    logic [31:0] len;
    logic        header_sent;
    act = ACT_NONE;
    sc = 1'b0;
    rc = 1'b0;
    prt = '0;
    len = '0;
    header_sent = 1'b0;
    case (ev.cmd)
      CMD_IRQ_FALL: begin
        irq_level = 1'b0;
        if (ctl_phase == PH_SEND_WAIT) begin
          ctl_phase = PH_SEND_MSG;
          act = ACT_TX_MSG;
          len = send_length;
        end else if (ctl_phase == PH_IDLE) begin
          ctl_phase = PH_RX_WAIT_CMD;
          tmo_count = tmo_ticks;
        end else if (ctl_phase == PH_RX_WAIT_MSG) begin
          ctl_phase = PH_RX_MSG;
          act = ACT_RX_MSG;
          prt = {hdr_bytes[5], hdr_bytes[4]};
          len = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
        end
      end
      CMD_IRQ_RISE: begin
        irq_level = 1'b1;
        if (ctl_phase == PH_SEND_DONE) begin
          ctl_phase = PH_IDLE;
          sc = 1'b1;
        end else if (ctl_phase == PH_RX_WAIT_CMD) begin
          ctl_phase = PH_RX_CMD;
          tmo_count = '0;
          hdr_index = 0;
          act = ACT_RX_HDR;
        end else begin
          // An unexpected rise drops back to idle.
          ctl_phase = PH_IDLE;
          tmo_count = '0;
        end
      end
      CMD_SEND_REQ: begin
        if (ctl_phase == PH_IDLE && irq_level) begin
          ctl_phase = PH_SEND_CMD;
          send_length = ev.length;
          {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]} = ev.length;
          {hdr_bytes[5], hdr_bytes[4]} = ev.port;
          for (int k = 0; k < HEADER_BYTES; k++) begin
            expected_results.push_back(make_result(1'b1, ACT_TX_HDR, hdr_bytes[k],
                                                   k == HEADER_BYTES - 1, 1'b0, 1'b0,
                                                   '0, '0));
          end
          header_sent = 1'b1;
        end
      end
      CMD_XFER_DONE: begin
        case (ctl_phase)
          PH_SEND_CMD: ctl_phase = PH_SEND_WAIT;
          PH_SEND_MSG: ctl_phase = PH_SEND_DONE;
          PH_RX_CMD: ctl_phase = PH_RX_WAIT_MSG;
          PH_RX_MSG: begin
            ctl_phase = PH_IDLE_WAIT;
            rc = 1'b1;
            prt = {hdr_bytes[5], hdr_bytes[4]};
            len = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
          end
          default: ;
        endcase
      end
      CMD_HDR_BYTE: begin
        // Bytes beyond the sixth are dropped.
        if (ctl_phase == PH_RX_CMD && hdr_index < HEADER_BYTES) begin
          hdr_bytes[hdr_index] = ev.rx_byte;
          hdr_index++;
        end
      end
      CMD_TICK: begin
        // A zero timeout expires on the first tick, like a timeout of one.
        if (ctl_phase == PH_RX_WAIT_CMD) begin
          if (tmo_count <= 16'd1) begin
            tmo_count = '0;
            ctl_phase = PH_IDLE;
          end else begin
            tmo_count--;
          end
        end
      end
      default: ;
    endcase
    if (!header_sent) begin
      expected_results.push_back(make_result(1'b0, act, '0, 1'b1, sc, rc, prt, len));
    end
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      note_fault($sformatf("result %0d: %s expected %h, got %h", result_count, name,
                           want, got));
    end
  endtask

  task automatic add_event(input logic [2:0] cmd, input logic [15:0] port,
                           input logic [31:0] length, input logic [7:0] rx_byte);
    event_t ev;
    ev.cmd = cmd;
    ev.port = port;
    ev.length = length;
    ev.rx_byte = rx_byte;
    pending_events.push_back(ev);
    queued_events++;
  endtask

  // Random payload for an event, with the extremes now and then.
  task automatic add_random_event(input logic [2:0] cmd);
    logic [15:0] prt;
    logic [31:0] len;
    int unsigned r;
    r = $urandom_range(0, 9);
    prt = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
    r = $urandom_range(0, 9);
    len = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    add_event(cmd, prt, len, 8'($urandom));
  endtask

  // An occasional stray or unknown event in the middle of a sequence.
  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 8) add_random_event(3'($urandom_range(0, 7)));
  endtask

  // One random sequence: mostly complete sends and receives, some timeouts
  // and some plain noise.
  task automatic add_sequence();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      add_random_event(CMD_SEND_REQ);
      maybe_noise();
      add_random_event(CMD_XFER_DONE);
      maybe_noise();
      add_random_event(CMD_IRQ_FALL);
      maybe_noise();
      add_random_event(CMD_XFER_DONE);
      maybe_noise();
      add_random_event(CMD_IRQ_RISE);
    end else if (kind < 70) begin
      add_random_event(CMD_IRQ_FALL);
      n = $urandom_range(0, 3);
      repeat (n) add_random_event(CMD_TICK);
      add_random_event(CMD_IRQ_RISE);
      n = ($urandom_range(0, 9) < 8) ? HEADER_BYTES : $urandom_range(0, 8);
      repeat (n) add_random_event(CMD_HDR_BYTE);
      maybe_noise();
      add_random_event(CMD_XFER_DONE);
      maybe_noise();
      add_random_event(CMD_IRQ_FALL);
      maybe_noise();
      add_random_event(CMD_XFER_DONE);
      add_random_event(CMD_IRQ_RISE);
    end else if (kind < 85) begin
      add_random_event(CMD_IRQ_FALL);
      n = $urandom_range(1, 8);
      repeat (n) add_random_event(CMD_TICK);
      if ($urandom_range(0, 1)) add_random_event(CMD_SEND_REQ);
      add_random_event(CMD_IRQ_RISE);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) add_random_event(3'($urandom_range(0, 7)));
    end
  endtask

  // Waits until every event is taken and every result has come back.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || drv_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    tmo_ticks = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Event driver: one transaction at a time, with a random gap after each.
  always @(posedge clk_i) begin : event_driver
    logic   valid_next;
    event_t ev;
    if (rst_ni) begin
      valid_next = drv_valid;
      if (drv_valid && s_axis_tready_o) begin
        predict_event('{cmd: drv_cmd, port: drv_data[15:0], length: drv_data[47:16],
                        rx_byte: drv_data[55:48]});
        valid_next = 1'b0;
      end
      if (!valid_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() > 0) begin
          ev = pending_events.pop_front();
          drv_cmd <= ev.cmd;
          drv_data <= {ev.rx_byte, ev.length, ev.port};
          valid_next = 1'b1;
          gap_left = pick_gap();
        end
      end
      drv_valid <= valid_next;
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && sink_ready) begin
        if (expected_results.size() == 0) begin
          note_fault($sformatf("result %0d arrived with none outstanding: data %h",
                               result_count, m_axis_tdata_o));
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", want.accepted, m_axis_tdata_o[0]);
          check_field("chip_select", want.chip_select, m_axis_tdata_o[1]);
          check_field("action", want.action, m_axis_tuser_o);
          check_field("tx_byte", want.tx_byte, m_axis_tdata_o[9:2]);
          check_field("last", want.last, m_axis_tlast_o);
          check_field("send_complete", want.send_complete, m_axis_tdata_o[10]);
          check_field("recv_complete", want.recv_complete, m_axis_tdata_o[11]);
          check_field("out_port", want.port, m_axis_tdata_o[27:12]);
          check_field("out_length", want.length, m_axis_tdata_o[59:28]);
          check_field("fsm_state", want.state, m_axis_tdata_o[63:60]);
        end
        result_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((drv_valid && s_axis_tready_o) || (m_axis_tvalid_o && sink_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("spi_master_message_handshake_unit: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [15:0] phase_timeout[5];
    phase_timeout = '{16'd1, 16'hFFFF, 16'd2, 16'($urandom_range(3, 6)), TIMEOUT_RESET};
    for (int k = 0; k < HEADER_BYTES; k++) hdr_bytes[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, with a zero timeout so the first tick expires.
    write_timeout(16'd0);
    // Full send with the largest port and length, which also fills the header.
    add_event(CMD_SEND_REQ, 16'hFFFF, 32'hFFFF_FFFF, 8'h00);
    add_event(CMD_XFER_DONE, 16'h0000, 32'h0, 8'hFF);
    add_event(CMD_IRQ_FALL, 16'hFFFF, 32'h0, 8'h00);
    add_event(CMD_XFER_DONE, 16'h0000, 32'hFFFF_FFFF, 8'hFF);
    add_event(CMD_IRQ_RISE, 16'h0000, 32'h0, 8'h00);
    // Send with zero fields, cut short by an unexpected rise.
    add_event(CMD_SEND_REQ, 16'h0000, 32'h0, 8'hFF);
    add_event(CMD_XFER_DONE, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_IRQ_RISE, 16'h0000, 32'h0, 8'h00);
    // Spurious IRQ pulse timed out, then a send refused while IRQ is low.
    add_event(CMD_IRQ_FALL, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_TICK, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_SEND_REQ, 16'h1234, 32'h89AB_CDEF, 8'h00);
    add_event(CMD_IRQ_RISE, 16'h0000, 32'h0, 8'h00);
    // Stray events in idle.
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'h77);
    add_event(CMD_TICK, 16'h0000, 32'h0, 8'h00);
    // Full receive, with one header byte too many.
    add_event(CMD_IRQ_FALL, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_IRQ_RISE, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'hFF);
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'hA5);
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'h5A);
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'h01);
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'h80);
    add_event(CMD_HDR_BYTE, 16'h0000, 32'h0, 8'hEE);
    add_event(CMD_XFER_DONE, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_IRQ_FALL, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_XFER_DONE, 16'h0000, 32'h0, 8'h00);
    add_event(CMD_IRQ_RISE, 16'h0000, 32'h0, 8'h00);
    // Undefined event codes.
    add_event(CMD_RESERVED_LO, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    add_event(CMD_RESERVED_HI, 16'h0000, 32'h0, 8'h00);
    settle();

    // Random phases, each under its own timeout setting.
    for (int p = 0; p < 5; p++) begin
      write_timeout(phase_timeout[p]);
      calm = (p == 2);
      queued_events = 0;
      while (queued_events < PHASE_EVENTS) add_sequence();
      settle();
    end

    if (expected_results.size() != 0) begin
      note_fault($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    if (fault_count == 0) begin
      $display("spi_master_message_handshake_unit: match");
    end else begin
      $display("spi_master_message_handshake_unit: mismatch");
    end
    $finish;
  end

endmodule
